FILE: hw/rtl/cpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_pkg
// Types and widths shared by the closest point of approach table.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int MulW  = 43;          // serial multiplier operand width
  localparam int ProdW = 2 * MulW;    // full product width
  localparam int NumW  = ProdW;       // divider numerator width
  localparam int DenW  = 35;          // divider denominator width
  localparam int QuoW  = 48;          // divider quotient width
  localparam int RootW = QuoW / 2;    // square root result width
  localparam int TermW = 50;          // signed product terms

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic               action;
    logic [5:0]         vehicle_slot;
    logic [5:0]         other_slot;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } req_item_t;

  typedef struct packed {
    logic        pair_valid;
    logic        will_approach;
    logic [23:0] approach_time;
    logic [23:0] approach_distance;
  } rsp_item_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } rec_t;

endpackage

FILE: hw/rtl/cpa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_req_if / cpa_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface cpa_req_if;
  logic               valid;
  logic               ready;
  cpa_pkg::req_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface cpa_rsp_if;
  logic               valid;
  logic               ready;
  cpa_pkg::rsp_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: hw/rtl/cpa_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_mul
// Unsigned bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module cpa_mul (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cpa_pkg::MulW-1:0]  a,
  input  logic [cpa_pkg::MulW-1:0]  b,
  output logic                      done,
  output logic [cpa_pkg::ProdW-1:0] p
);
  import cpa_pkg::*;

  localparam int CW = $clog2(MulW + 1);

  logic             run;
  logic [CW-1:0]    cnt;
  logic [ProdW-1:0] ash;
  logic [MulW-1:0]  bsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(MulW);
        p   <= '0;
        ash <= ProdW'(a);
        bsh <= b;
      end else if (run) begin
        if (bsh[0]) begin
          p <= p + ash;
        end
        ash <= ash << 1;
        bsh <= bsh >> 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/cpa_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_div
// Restoring divider, one quotient bit per cycle, saturating on overflow.
// ----------------------------------------------------------------------------
module cpa_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [cpa_pkg::NumW-1:0] num,
  input  logic [cpa_pkg::DenW-1:0] den,
  output logic                     done,
  output logic [cpa_pkg::QuoW-1:0] q
);
  import cpa_pkg::*;

  localparam int CW = $clog2(QuoW + 1);
  localparam int HW = NumW - QuoW;

  logic            run;
  logic [CW-1:0]   cnt;
  logic [DenW-1:0] rem;
  logic [QuoW-1:0] nsh;
  logic [DenW:0]   r2;

  assign r2 = {rem, nsh[QuoW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (num[NumW-1:QuoW] >= HW'(den)) begin
          q    <= '1;
          done <= 1'b1;
        end else begin
          rem <= num[QuoW+DenW-1:QuoW];
          nsh <= num[QuoW-1:0];
          q   <= '0;
          cnt <= CW'(QuoW);
          run <= 1'b1;
        end
      end else if (run) begin
        if (r2 >= {1'b0, den}) begin
          rem <= DenW'(r2 - {1'b0, den});
          q   <= {q[QuoW-2:0], 1'b1};
        end else begin
          rem <= DenW'(r2);
          q   <= {q[QuoW-2:0], 1'b0};
        end
        nsh <= nsh << 1;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/cpa_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpa_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module cpa_sqrt (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cpa_pkg::QuoW-1:0]  x,
  output logic                      done,
  output logic [cpa_pkg::RootW-1:0] root
);
  import cpa_pkg::*;

  localparam int CW = $clog2(RootW + 1);
  localparam int RW = RootW + 2;

  logic            run;
  logic [CW-1:0]   cnt;
  logic [RW-1:0]   rem;
  logic [QuoW-1:0] xs;
  logic [RW+1:0]   r4;
  logic [RW+1:0]   trial;

  assign r4    = {rem, xs[QuoW-1:QuoW-2]};
  assign trial = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        root <= '0;
        xs   <= x;
        cnt  <= CW'(RootW);
        run  <= 1'b1;
      end else if (run) begin
        if (r4 >= trial) begin
          rem  <= RW'(r4 - trial);
          root <= {root[RootW-2:0], 1'b1};
        end else begin
          rem  <= RW'(r4);
          root <= {root[RootW-2:0], 1'b0};
        end
        xs  <= xs << 2;
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/closest_point_of_approach_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// closest_point_of_approach_table_core
// Vehicle table with closest point of approach queries.
// ----------------------------------------------------------------------------
// A store beat produces no response. A query beat on two stored slots runs
// two table reads, nine passes of the bit-serial multiplier (eight difference
// products, then the squared cross term), up to two passes of the restoring
// divider (time, then squared distance) and a square root; a query on an
// unstored slot gets an all-zero response. The sequencer handles one request
// at a time; the finished response sits in an output register until taken.
module closest_point_of_approach_table_core #(
  parameter int SLOT_COUNT = 64
) (
  input logic      clk,
  input logic      rst,
  cpa_req_if.sink  req,
  cpa_rsp_if.source rsp
);
  import cpa_pkg::*;

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int XW = ((AW > 6) ? AW : 6) + 1;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_RDA   = 12'b000000000010,
    S_RDB   = 12'b000000000100,
    S_LAT   = 12'b000000001000,
    S_MUL   = 12'b000000010000,
    S_MULW  = 12'b000000100000,
    S_DIVT  = 12'b000001000000,
    S_DIVTW = 12'b000010000000,
    S_DIVD  = 12'b000100000000,
    S_DIVDW = 12'b001000000000,
    S_SQW   = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state;

  rec_t                  mem [SLOT_COUNT];
  rec_t                  rdata;
  rec_t                  rec_a;
  logic [AW-1:0]         rd_addr;
  logic [SLOT_COUNT-1:0] slot_valid;

  logic [XW-1:0] sa_x, sb_x;
  logic          sa_ok, sb_ok;
  logic [AW-1:0] sa, sb;

  logic signed [24:0] dpx, dpy, dvx, dvy;
  logic signed [24:0] opa, opb;
  logic [3:0]         k;
  logic signed [TermW-1:0] prod [8];
  logic [ProdW-1:0]   crsq;

  logic signed [TermW-1:0] t1, t2, xprod, cr;
  logic [TermW-1:0]   vv;
  logic [TermW:0]     p2, tsum;
  logic               appr;
  logic               prod_neg;

  logic               mul_start, mul_done;
  logic [MulW-1:0]    mul_a, mul_b;
  logic [ProdW-1:0]   mul_p;
  logic               div_start, div_done;
  logic [NumW-1:0]    div_num;
  logic [DenW-1:0]    div_den;
  logic [QuoW-1:0]    div_q;
  logic               sq_start, sq_done;
  logic [RootW-1:0]   sq_root;

  logic [23:0] tm;
  rsp_item_t   res;

  assign sa_x  = XW'(req.item.vehicle_slot);
  assign sb_x  = XW'(req.item.other_slot);
  assign sa_ok = sa_x < XW'(SLOT_COUNT);
  assign sb_ok = sb_x < XW'(SLOT_COUNT);

  assign req.ready = (state == S_IDLE);

  // table
  assign rd_addr = (state == S_RDA) ? sa : sb;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready && req.item.action == ACT_STORE && sa_ok) begin
      mem[sa_x[AW-1:0]] <= '{pos_x: req.item.pos_x, pos_y: req.item.pos_y,
                             vel_x: req.item.vel_x, vel_y: req.item.vel_y};
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (req.valid && req.ready && req.item.action == ACT_STORE && sa_ok) begin
      slot_valid[sa_x[AW-1:0]] <= 1'b1;
    end
  end

  // derived terms
  assign t1    = -prod[0];
  assign t2    = -prod[1];
  assign vv    = TermW'(prod[2] + prod[3]);
  assign xprod = prod[4] - prod[5];
  assign cr    = xprod[TermW-1] ? -xprod : xprod;
  assign p2    = (TermW+1)'(prod[6]) + (TermW+1)'(prod[7]);
  assign tsum  = (TermW+1)'(t1) + (TermW+1)'(t2);
  assign appr  = !t1[TermW-1] && !t2[TermW-1] && (vv != '0);

  always_comb begin
    unique case (k[2:0])
      3'd0: begin opa = dpx; opb = dvx; end
      3'd1: begin opa = dpy; opb = dvy; end
      3'd2: begin opa = dvx; opb = dvx; end
      3'd3: begin opa = dvy; opb = dvy; end
      3'd4: begin opa = dpx; opb = dvy; end
      3'd5: begin opa = dpy; opb = dvx; end
      3'd6: begin opa = dpx; opb = dpx; end
      default: begin opa = dpy; opb = dpy; end
    endcase
  end

  assign prod_neg = opa[24] ^ opb[24];
  assign mul_a = k[3] ? MulW'(cr) : MulW'(opa[24] ? -opa : opa);
  assign mul_b = k[3] ? MulW'(cr) : MulW'(opb[24] ? -opb : opb);
  assign mul_start = (state == S_MUL);

  assign div_start = (state == S_DIVT) || (state == S_DIVD);
  always_comb begin
    if (state == S_DIVT) begin
      div_num = NumW'(tsum) << 36;
      div_den = vv[DenW-1:0];
    end else if (vv != '0) begin
      div_num = crsq;
      div_den = vv[DenW-1:0];
    end else begin
      div_num = NumW'(p2);
      div_den = DenW'(1);
    end
  end

  assign sq_start = (state == S_DIVDW) && div_done;

  cpa_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  cpa_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .q(div_q)
  );

  cpa_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .x(div_q),
    .done(sq_done), .root(sq_root)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp.valid <= 1'b0;
      k         <= '0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.item.action == ACT_QUERY) begin
            sa <= sa_x[AW-1:0];
            sb <= sb_x[AW-1:0];
            if (sa_ok && sb_ok && slot_valid[sa_x[AW-1:0]] &&
                slot_valid[sb_x[AW-1:0]]) begin
              state <= S_RDA;
            end else begin
              res   <= '0;
              state <= S_DONE;
            end
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          rec_a <= rdata;
          state <= S_LAT;
        end
        S_LAT: begin
          dpx   <= 25'(rec_a.pos_x) - 25'(rdata.pos_x);
          dpy   <= 25'(rec_a.pos_y) - 25'(rdata.pos_y);
          dvx   <= 25'(rec_a.vel_x) - 25'(rdata.vel_x);
          dvy   <= 25'(rec_a.vel_y) - 25'(rdata.vel_y);
          k     <= '0;
          state <= S_MUL;
        end
        S_MUL: state <= S_MULW;
        S_MULW: begin
          if (mul_done) begin
            if (k[3]) begin
              crsq  <= mul_p;
              tm    <= '0;
              state <= appr ? S_DIVT : S_DIVD;
            end else begin
              prod[k[2:0]] <= prod_neg ? -$signed({1'b0, mul_p[TermW-2:0]})
                                       : $signed({1'b0, mul_p[TermW-2:0]});
              k     <= k + 1'b1;
              state <= S_MUL;
            end
          end
        end
        S_DIVT: state <= S_DIVTW;
        S_DIVTW: begin
          if (div_done) begin
            tm    <= div_q[QuoW-1:QuoW-24];
            state <= S_DIVD;
          end
        end
        S_DIVD: state <= S_DIVDW;
        S_DIVDW: begin
          if (div_done) begin
            state <= S_SQW;
          end
        end
        S_SQW: begin
          if (sq_done) begin
            res   <= '{pair_valid: 1'b1, will_approach: appr,
                       approach_time: tm, approach_distance: sq_root};
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.item  <= res;
            rsp.valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: bench/tb_closest_point_of_approach_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_closest_point_of_approach_table_core
// Self-checking bench for the vehicle table with closest-approach queries.
// A directed table covers the empty table, the field extremes, head-on,
// diverging, equal-velocity and saturating pairs. Random store and query
// beats follow. Each query response is checked against its directed row or a
// table model. Channels throttle at random save in the third of three phases.
// ----------------------------------------------------------------------------
module tb_closest_point_of_approach_table_core;
  import cpa_pkg::*;

  typedef struct {
    req_item_t item;
    bit        typed;
    rsp_item_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cpa_req_if req ();
  cpa_rsp_if rsp ();

  closest_point_of_approach_table_core #(.SLOT_COUNT(64)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always #5 clk = ~clk;

  rec_t      vehicle_tbl [64];
  bit        vehicle_live[64];
  rsp_item_t pending_rsp[$];
  int        err_count    = 0;
  int        store_count  = 0;
  int        query_count  = 0;
  int        checked      = 0;
  int        approach_hit = 0;
  int        send_idle    = 24;
  int        recv_idle    = 86;

  task automatic report(string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    err_count++;
  endtask

  function automatic logic [23:0] root_ratio(logic [127:0] den, logic [127:0] rhs);
    logic [127:0] d;
    logic [127:0] c;
    d = '0;
    for (int b = 23; b >= 0; b--) begin
      c = d | (128'd1 << b);
      if (c * c * den <= rhs) d = c;
    end
    return d[23:0];
  endfunction

  function automatic rsp_item_t cpa_of_pair(int sa, int sb);
    rsp_item_t    r;
    longint       dpx, dpy, dvx, dvy, t1, t2, vv, cr, p2;
    logic [127:0] quo;
    r = '0;
    if (!vehicle_live[sa] || !vehicle_live[sb]) return r;
    dpx = longint'(vehicle_tbl[sa].pos_x) - longint'(vehicle_tbl[sb].pos_x);
    dpy = longint'(vehicle_tbl[sa].pos_y) - longint'(vehicle_tbl[sb].pos_y);
    dvx = longint'(vehicle_tbl[sa].vel_x) - longint'(vehicle_tbl[sb].vel_x);
    dvy = longint'(vehicle_tbl[sa].vel_y) - longint'(vehicle_tbl[sb].vel_y);
    t1 = -(dpx * dvx);
    t2 = -(dpy * dvy);
    vv = dvx * dvx + dvy * dvy;
    r.pair_valid = 1'b1;
    if (t1 >= 0 && t2 >= 0 && vv != 0) begin
      r.will_approach = 1'b1;
      quo = ({64'd0, t1 + t2} << 12) / {64'd0, vv};
      r.approach_time = (quo > 128'd16777215) ? 24'hFFFFFF : quo[23:0];
    end
    if (vv != 0) begin
      cr = dpx * dvy - dpy * dvx;
      if (cr < 0) cr = -cr;
      r.approach_distance = root_ratio({64'd0, vv}, {64'd0, cr} * {64'd0, cr});
    end else begin
      p2 = dpx * dpx + dpy * dpy;
      r.approach_distance = root_ratio(128'd1, {64'd0, p2});
    end
    return r;
  endfunction

  task automatic send(req_item_t it, bit typed, rsp_item_t want);
    while ($urandom_range(99) < send_idle) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.item  = it;
    do @(posedge clk); while (!req.ready);
    if (it.action == ACT_STORE) begin
      vehicle_tbl[it.vehicle_slot]  = '{it.pos_x, it.pos_y, it.vel_x, it.vel_y};
      vehicle_live[it.vehicle_slot] = 1'b1;
      store_count++;
    end else begin
      pending_rsp.push_back(typed ? want : cpa_of_pair(it.vehicle_slot, it.other_slot));
      query_count++;
    end
    @(negedge clk);
  endtask

  function automatic req_item_t mk_store(int s, int px, int py, int vx, int vy);
    req_item_t it;
    it = '0;
    it.action       = ACT_STORE;
    it.vehicle_slot = 6'(s);
    it.pos_x        = 24'(px);
    it.pos_y        = 24'(py);
    it.vel_x        = 16'(vx);
    it.vel_y        = 16'(vy);
    return it;
  endfunction

  function automatic req_item_t mk_query(int sa, int sb);
    req_item_t it;
    it = '0;
    it.action       = ACT_QUERY;
    it.vehicle_slot = 6'(sa);
    it.other_slot   = 6'(sb);
    return it;
  endfunction

  function automatic req_item_t rand_item();
    req_item_t    it;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(req_item_t)-1:0];
    it.action = ($urandom_range(99) < 55) ? ACT_QUERY : ACT_STORE;
    if ($urandom_range(9) < 8) begin
      it.vehicle_slot = 6'($urandom_range(15));
      it.other_slot   = 6'($urandom_range(15));
    end
    if ($urandom_range(1)) begin
      it.pos_x = $signed(24'($urandom_range(8191))) - 24'sd4096;
      it.pos_y = $signed(24'($urandom_range(8191))) - 24'sd4096;
      it.vel_x = $signed(16'($urandom_range(2047))) - 16'sd1024;
      it.vel_y = $signed(16'($urandom_range(2047))) - 16'sd1024;
    end
    return it;
  endfunction

  always @(negedge clk) begin
    rsp.ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_rsp.size() == 0) begin
        report("response with nothing outstanding");
      end else begin
        want = pending_rsp.pop_front();
        checked++;
        if (want.will_approach) approach_hit++;
        if (rsp.item.pair_valid !== want.pair_valid)
          report($sformatf("pair_valid %0b want %0b", rsp.item.pair_valid,
                           want.pair_valid));
        if (rsp.item.will_approach !== want.will_approach)
          report($sformatf("will_approach %0b want %0b", rsp.item.will_approach,
                           want.will_approach));
        if (rsp.item.approach_time !== want.approach_time)
          report($sformatf("approach_time %0d want %0d", rsp.item.approach_time,
                           want.approach_time));
        if (rsp.item.approach_distance !== want.approach_distance)
          report($sformatf("approach_distance %0d want %0d",
                           rsp.item.approach_distance, want.approach_distance));
      end
    end
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("tb_closest_point_of_approach_table_core: done, errors");
    $finish;
  end

  initial begin
    dir_row_t rows[$];
    int       wait_cnt;
    req.valid = 1'b0;
    req.item  = '0;
    foreach (vehicle_live[i]) vehicle_live[i] = 1'b0;

    rows.push_back('{mk_query(0, 63), 1'b1, rsp_item_t'('0)});
    rows.push_back('{mk_query(63, 63), 1'b1, rsp_item_t'('0)});
    rows.push_back('{mk_store(0, 8388607, 8388607, 32767, 32767), 1'b0, '0});
    rows.push_back('{mk_query(0, 63), 1'b1, rsp_item_t'('0)});
    rows.push_back('{mk_store(63, -8388608, -8388608, -32768, -32768), 1'b0, '0});
    rows.push_back('{mk_query(0, 63), 1'b0, '0});
    rows.push_back('{mk_query(63, 0), 1'b0, '0});
    rows.push_back('{mk_query(0, 0), 1'b1, rsp_item_t'({2'b10, 24'd0, 24'd0})});
    rows.push_back('{mk_store(1, 0, 0, 0, 0), 1'b0, '0});
    rows.push_back('{mk_store(2, 160, 0, -256, 0), 1'b0, '0});
    // head-on at 1 m/s from 10 m: 10 s, zero miss distance
    rows.push_back('{mk_query(2, 1), 1'b1, rsp_item_t'({2'b11, 24'd2560, 24'd0})});
    rows.push_back('{mk_query(1, 2), 1'b1, rsp_item_t'({2'b11, 24'd2560, 24'd0})});
    // equal velocities: distance is the plain separation
    rows.push_back('{mk_store(3, 0, 160, 0, 0), 1'b0, '0});
    rows.push_back('{mk_query(3, 1), 1'b1, rsp_item_t'({2'b10, 24'd0, 24'd160})});
    // diverging on one axis
    rows.push_back('{mk_store(4, 160, 0, 256, 0), 1'b0, '0});
    rows.push_back('{mk_query(4, 1), 1'b1, rsp_item_t'({2'b10, 24'd0, 24'd0})});
    // far apart, crawling closer: time saturates
    rows.push_back('{mk_store(5, 8388607, 0, -1, 0), 1'b0, '0});
    rows.push_back('{mk_store(6, -8388608, 1, 0, 0), 1'b0, '0});
    rows.push_back('{mk_query(5, 6), 1'b0, '0});
    rows.push_back('{mk_store(7, -8388608, 8388607, 32767, -32768), 1'b0, '0});
    rows.push_back('{mk_query(7, 0), 1'b0, '0});
    rows.push_back('{mk_query(5, 7), 1'b0, '0});
    rows.push_back('{mk_store(5, 100, -100, 300, -20), 1'b0, '0});
    rows.push_back('{mk_query(5, 2), 1'b0, '0});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].want);
    for (int n = 0; n < 1200; n++) begin
      if (n == 400) begin
        send_idle = 86;
        recv_idle = 24;
      end else if (n == 800) begin
        send_idle = 0;
        recv_idle = 0;
      end
      send(rand_item(), 1'b0, '0);
    end
    req.valid = 1'b0;

    wait_cnt = 0;
    while (pending_rsp.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (1200) @(posedge clk);
    if (pending_rsp.size() != 0)
      report($sformatf("%0d responses never arrived", pending_rsp.size()));

    $display("covered %0d stores, %0d queries; %0d responses checked, %0d approaches",
             store_count, query_count, checked, approach_hit);
    if (err_count == 0) begin
      $display("tb_closest_point_of_approach_table_core: done, clean");
    end else begin
      $display("tb_closest_point_of_approach_table_core: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/cpa_pkg.sv
hw/rtl/cpa_if.sv
hw/rtl/cpa_mul.sv
hw/rtl/cpa_div.sv
hw/rtl/cpa_sqrt.sv
hw/rtl/closest_point_of_approach_table_core.sv
bench/tb_closest_point_of_approach_table_core.sv
